// ===== rtl/core/rwmc_pkg.sv =====
// rwmc_pkg: shared types and constants of the random walk maze carver
// no dependencies; used by random_walk_maze_carver and rwmc_out_reg in rtl/core
package rwmc_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_MAZE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAZE_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd63;
    localparam logic [CFG_DATA_W-1:0] SIZE_MIN   = 7'd3;

    // direction codes of the random draw
    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    // last of the four tries
    localparam logic [1:0] TRY_LAST = 2'd3;

    // output coordinate width
    localparam int OUT_COORD_W = 6;

    typedef struct packed {
        logic       start_new;
        logic [1:0] random_dir;
    } in_item_t;

    typedef struct packed {
        logic [OUT_COORD_W-1:0] cell_col;
        logic [OUT_COORD_W-1:0] cell_row;
        logic                   last_of_run;
        logic                   maze_done;
    } out_item_t;

endpackage

// ===== rtl/core/random_walk_maze_carver.sv =====
// random_walk_maze_carver: top level, walk sequencer around the wall bit ram
// depends on rwmc_pkg, rwmc_ram and rwmc_out_reg
//
//  channel   ports                                   direction
//  input     s_valid, s_ready, s_item (in_item_t)    in
//  result    m_valid, m_ready, m_item (out_item_t)   out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   in
//
// an item is accepted in idle, then each direction try either fails its bounds
// test or passes it and makes two registered ram reads, near cell then far cell,
// then the check, up to four tries; a carve or the finish adds two ram writes and two
// results, and a draw after the finish is accepted and does nothing.
// after reset and after every start item the ram is swept to walls, one entry
// a cycle over all MAX_WIDTH*MAX_HEIGHT entries, with s_ready low; config is always taken.
// a stalled result channel holds the sequencer only in its result cycles.
module random_walk_maze_carver #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rwmc_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rwmc_pkg::out_item_t                 m_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rwmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rwmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int XW    = ((CW > RW) ? CW : RW) + 2;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic signed [XW-1:0] MAXW_S = XW'(MAX_WIDTH);
    localparam logic signed [XW-1:0] MAXH_S = XW'(MAX_HEIGHT);
    localparam logic signed [XW-1:0] ONE_S  = XW'(1);
    localparam logic signed [XW-1:0] TWO_S  = XW'(2);
    localparam logic signed [XW-1:0] MONE_S = XW'(-1);
    localparam logic signed [XW-1:0] ZERO_S = XW'(0);
    localparam logic signed [XW-1:0] MIN_S  = XW'(3);

    localparam logic [AW-1:0] ADDR_START = AW'(MAX_WIDTH + 1);
    localparam logic [AW-1:0] ADDR_LAST  = AW'(DEPTH - 1);

    // sequencer states
    localparam logic [3:0] ST_SWEEP = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_TRY   = 4'd2;
    localparam logic [3:0] ST_RD2   = 4'd3;
    localparam logic [3:0] ST_CHK   = 4'd4;
    localparam logic [3:0] ST_WR1   = 4'd5;
    localparam logic [3:0] ST_WR2   = 4'd6;
    localparam logic [3:0] ST_EM1   = 4'd7;
    localparam logic [3:0] ST_EM2   = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [CW-1:0] walk_col_reg, walk_col_next;
    logic [RW-1:0] walk_row_reg, walk_row_next;
    logic [CW-1:0] scan_col_reg, scan_col_next;
    logic [RW-1:0] scan_row_reg, scan_row_next;
    logic          walking_reg, walking_next;
    logic          finished_reg, finished_next;
    logic [1:0]    dir_reg, dir_next;
    logic [1:0]    try_reg, try_next;
    logic [rwmc_pkg::CFG_DATA_W-1:0] cfg_width_reg, cfg_height_reg;

    // payload registers: the two cells of a try, or entry and exit
    logic [CW-1:0] col1_reg, col1_next;
    logic [RW-1:0] row1_reg, row1_next;
    logic [CW-1:0] col2_reg, col2_next;
    logic [RW-1:0] row2_reg, row2_next;
    logic          wall1_reg, wall1_next;
    logic          done_reg, done_next;

    logic signed [XW-1:0] w_s, h_s;
    logic signed [XW-1:0] dx_s, dy_s, c1_s, r1_s, c2_s, r2_s;
    logic signed [XW-1:0] sc_s, sr_s;
    logic                 try_ok;
    logic                 scan_end;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic          ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic          ram_rd_data;

    logic                out_load_valid;
    logic                out_load_ready;
    rwmc_pkg::out_item_t out_load_item;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] col,
                                                input logic [RW-1:0] row);
        return AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= rwmc_pkg::SIZE_RESET;
            cfg_height_reg <= rwmc_pkg::SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rwmc_pkg::REG_MAZE_WIDTH:  cfg_width_reg  <= cfg_data;
                rwmc_pkg::REG_MAZE_HEIGHT: cfg_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the sizes to 3 .. max
    always_comb begin
        if (cfg_width_reg < rwmc_pkg::SIZE_MIN) begin
            w_s = MIN_S;
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            w_s = MAXW_S;
        end else begin
            w_s = XW'(cfg_width_reg);
        end
        if (cfg_height_reg < rwmc_pkg::SIZE_MIN) begin
            h_s = MIN_S;
        end else if (32'(cfg_height_reg) > 32'(MAX_HEIGHT)) begin
            h_s = MAXH_S;
        end else begin
            h_s = XW'(cfg_height_reg);
        end
    end

    // cells of the current try and their bounds test
    always_comb begin
        dx_s = ZERO_S;
        dy_s = ZERO_S;
        unique case (dir_reg)
            rwmc_pkg::DIR_EAST:  dx_s = ONE_S;
            rwmc_pkg::DIR_SOUTH: dy_s = ONE_S;
            rwmc_pkg::DIR_WEST:  dx_s = MONE_S;
            rwmc_pkg::DIR_NORTH: dy_s = MONE_S;
            default: ;
        endcase
        c1_s = $signed(XW'(walk_col_reg)) + dx_s;
        r1_s = $signed(XW'(walk_row_reg)) + dy_s;
        c2_s = c1_s + dx_s;
        r2_s = r1_s + dy_s;
        try_ok = (c2_s > ZERO_S) && (c2_s < w_s) && (r2_s > ZERO_S) && (r2_s < h_s)
              && (c1_s >= ZERO_S) && (c1_s < MAXW_S)
              && (r1_s >= ZERO_S) && (r1_s < MAXH_S);
    end

    // next scan start cell after a walk ends
    always_comb begin
        sc_s = $signed(XW'(scan_col_reg)) + TWO_S;
        sr_s = $signed(XW'(scan_row_reg));
        if (sc_s >= w_s) begin
            sc_s = ONE_S;
            sr_s = sr_s + TWO_S;
        end
        scan_end = (sr_s >= h_s);
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        walk_col_next  = walk_col_reg;
        walk_row_next  = walk_row_reg;
        scan_col_next  = scan_col_reg;
        scan_row_next  = scan_row_reg;
        walking_next   = walking_reg;
        finished_next  = finished_reg;
        dir_next       = dir_reg;
        try_next       = try_reg;
        col1_next      = col1_reg;
        row1_next      = row1_reg;
        col2_next      = col2_reg;
        row2_next      = row2_reg;
        wall1_next     = wall1_reg;
        done_next      = done_reg;

        ram_wr_en      = 1'b0;
        ram_wr_addr    = cell_addr(col1_reg, row1_reg);
        ram_wr_data    = 1'b0;
        ram_rd_addr    = cell_addr(col2_reg, row2_reg);
        out_load_valid = 1'b0;
        out_load_item  = '{cell_col:    rwmc_pkg::OUT_COORD_W'(col1_reg),
                           cell_row:    rwmc_pkg::OUT_COORD_W'(row1_reg),
                           last_of_run: 1'b0,
                           maze_done:   done_reg};

        unique case (state_reg) inside
            ST_SWEEP: begin
                // refill with walls, start cell open
                ram_wr_en   = 1'b1;
                ram_wr_addr = sweep_cnt_reg;
                ram_wr_data = (sweep_cnt_reg != ADDR_START);
                sweep_cnt_next = sweep_cnt_reg + AW'(1);
                if (sweep_cnt_reg == ADDR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.start_new) begin
                        sweep_cnt_next = '0;
                        walk_col_next  = CW'(1);
                        walk_row_next  = RW'(1);
                        scan_col_next  = CW'(1);
                        scan_row_next  = RW'(1);
                        walking_next   = 1'b0;
                        finished_next  = 1'b0;
                        state_next     = ST_SWEEP;
                    end else if (!finished_reg) begin
                        if (!walking_reg) begin
                            walk_col_next = scan_col_reg;
                            walk_row_next = scan_row_reg;
                            walking_next  = 1'b1;
                        end
                        dir_next   = s_item.random_dir;
                        try_next   = 2'd0;
                        state_next = ST_TRY;
                    end
                end
            end
            ST_TRY, ST_CHK: begin
                if (state_reg == ST_TRY && try_ok) begin
                    // read the near cell now, the far cell next cycle
                    ram_rd_addr = cell_addr(CW'(c1_s), RW'(r1_s));
                    col1_next   = CW'(c1_s);
                    row1_next   = RW'(r1_s);
                    col2_next   = CW'(c2_s);
                    row2_next   = RW'(r2_s);
                    state_next  = ST_RD2;
                end else if (state_reg == ST_CHK && wall1_reg && ram_rd_data) begin
                    // carve both cells
                    walk_col_next = col2_reg;
                    walk_row_next = row2_reg;
                    done_next     = 1'b0;
                    state_next    = ST_WR1;
                end else if (try_reg != rwmc_pkg::TRY_LAST) begin
                    dir_next   = dir_reg + 2'd1;
                    try_next   = try_reg + 2'd1;
                    state_next = ST_TRY;
                end else begin
                    // walk is stuck: move the scan on
                    walking_next  = 1'b0;
                    scan_col_next = CW'(sc_s);
                    scan_row_next = RW'(sr_s);
                    if (scan_end) begin
                        finished_next = 1'b1;
                        col1_next     = CW'(1);
                        row1_next     = RW'(0);
                        col2_next     = CW'(w_s - TWO_S);
                        row2_next     = RW'(h_s - ONE_S);
                        done_next     = 1'b1;
                        state_next    = ST_WR1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD2: begin
                wall1_next = ram_rd_data;
                state_next = ST_CHK;
            end
            ST_WR1: begin
                ram_wr_en  = 1'b1;
                state_next = ST_WR2;
            end
            ST_WR2: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cell_addr(col2_reg, row2_reg);
                state_next  = ST_EM1;
            end
            ST_EM1: begin
                out_load_valid = 1'b1;
                if (out_load_ready) begin
                    state_next = ST_EM2;
                end
            end
            ST_EM2: begin
                out_load_valid = 1'b1;
                out_load_item  = '{cell_col:    rwmc_pkg::OUT_COORD_W'(col2_reg),
                                   cell_row:    rwmc_pkg::OUT_COORD_W'(row2_reg),
                                   last_of_run: 1'b1,
                                   maze_done:   done_reg};
                if (out_load_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            walk_col_reg  <= CW'(1);
            walk_row_reg  <= RW'(1);
            scan_col_reg  <= CW'(1);
            scan_row_reg  <= RW'(1);
            walking_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            dir_reg       <= rwmc_pkg::DIR_EAST;
            try_reg       <= 2'd0;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            walk_col_reg  <= walk_col_next;
            walk_row_reg  <= walk_row_next;
            scan_col_reg  <= scan_col_next;
            scan_row_reg  <= scan_row_next;
            walking_reg   <= walking_next;
            finished_reg  <= finished_next;
            dir_reg       <= dir_next;
            try_reg       <= try_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        col1_reg  <= col1_next;
        row1_reg  <= row1_next;
        col2_reg  <= col2_next;
        row2_reg  <= row2_next;
        wall1_reg <= wall1_next;
        done_reg  <= done_next;
    end

    // wall bit grid, 1 = wall
    rwmc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result register
    rwmc_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (out_load_valid),
        .load_item  (out_load_item),
        .load_ready (out_load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

// ===== rtl/core/rwmc_ram.sv =====
// rwmc_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module rwmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rwmc_out_reg.sv =====
// rwmc_out_reg: output register of the result channel
// depends on rwmc_pkg for the result type
module rwmc_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load_valid,
    input  rwmc_pkg::out_item_t load_item,
    output logic              load_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output rwmc_pkg::out_item_t m_item
);

    logic                valid_reg;
    rwmc_pkg::out_item_t item_reg;

    // free when empty or when the held result transfers this cycle
    assign load_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_valid && load_ready) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            item_reg <= load_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule
